>>> hw/rtl/calibrated_bang_bang_servo_macros.svh
// Assertion macros shared by the servo modules.
`ifndef CALIBRATED_BANG_BANG_SERVO_MACROS_SVH
`define CALIBRATED_BANG_BANG_SERVO_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CBBS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbbs check failed");
`define CBBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbbs check failed");
`else
`define CBBS_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define CBBS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/cbbs_pkg.sv
package cbbs_pkg;

   localparam int DEF_POLY_TERMS = 21;
   localparam int DEF_ADC_BITS   = 12;
   localparam int COEF_COUNT     = 21;
   localparam int ACC_W          = 128;
   localparam int FRAC_W         = 108;
   localparam int CMD_W          = 14;
   localparam int CMD_FRAC_W     = 10;
   localparam int HALF_W         = ACC_W / 2;
   localparam int PLO_W          = HALF_W + CMD_W;
   localparam int PHI_W          = ACC_W + CMD_W - HALF_W;
   localparam int SHIFT_W        = ACC_W + CMD_W - CMD_FRAC_W;
   localparam int SUM_W          = SHIFT_W + 1;
   localparam int TERM_IDX_W     = 5;
   localparam int WIDE_W         = 192;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_MUL_LO,
      OP_MUL_HI,
      OP_ADD,
      OP_SCALE,
      OP_ROUND
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_ADD,
      ST_SCALE,
      ST_ROUND,
      ST_DECIDE
   } state_type;

   typedef enum logic [1:0] {
      DIR_IDLE  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT  = 2'd2
   } dir_type;

   typedef struct packed {
      op_type                  op;
      logic [TERM_IDX_W-1:0]   term;
      logic                    ready;
      logic                    finish;
   } cbbs_ctl_type;

   // Each coefficient is mantissa * 10^-exponent, with a sign flag.
   localparam logic [63:0] COEF_MANT [COEF_COUNT] = '{
      64'd10940883381103002, 64'd33836477185904892, 64'd86168336840589527,
      64'd72898864709400185, 64'd65634869157701475, 64'd43041284300853841,
      64'd27865035485863790, 64'd84485921561660623, 64'd12295215776175377,
      64'd36304431194088678, 64'd11407813908880530, 64'd69455207057115884,
      64'd15831820248467315, 64'd24464645786585510, 64'd12748257280927221,
      64'd64620006332451161, 64'd28653037259852716, 64'd33937637701018807,
      64'd14775025027190523, 64'd82774635566028758, 64'd16178431560148211
   };

   localparam int COEF_EXP [COEF_COUNT] = '{
      19, 18, 18, 18, 19, 18, 18, 19, 19, 21, 21,
      23, 23, 24, 25, 27, 27, 28, 29, 32, 32
   };

   localparam logic COEF_NEG [COEF_COUNT] = '{
      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0
   };

   // Evaluated at elaboration only: rounds the magnitude of the decimal value
   // half up to a multiple of 2^-108.
   function automatic logic signed [ACC_W-1:0] coef_value(input int k);
      logic [WIDE_W-1:0] v;
      int                i;
      v = WIDE_W'(COEF_MANT[k]) << (FRAC_W + 1);
      for (i = 0; i < COEF_EXP[k]; i++) begin
         v = v / 192'd10;
      end
      v = (v + 192'd1) >> 1;
      if (COEF_NEG[k]) begin
         v = -v;
      end
      return v[ACC_W-1:0];
   endfunction

   localparam logic signed [ACC_W-1:0] COEF_TABLE [COEF_COUNT] = '{
      coef_value(0),  coef_value(1),  coef_value(2),  coef_value(3),
      coef_value(4),  coef_value(5),  coef_value(6),  coef_value(7),
      coef_value(8),  coef_value(9),  coef_value(10), coef_value(11),
      coef_value(12), coef_value(13), coef_value(14), coef_value(15),
      coef_value(16), coef_value(17), coef_value(18), coef_value(19),
      coef_value(20)
   };

endpackage

>>> hw/rtl/cbbs_ctrl.sv
`include "calibrated_bang_bang_servo_macros.svh"

module cbbs_ctrl #(
   parameter int POLY_TERMS = cbbs_pkg::DEF_POLY_TERMS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_action,
   input  logic                  out_free,
   output cbbs_pkg::cbbs_ctl_type ctl
);
   import cbbs_pkg::*;

   localparam int TERM_W = (POLY_TERMS > 1) ? $clog2(POLY_TERMS) : 1;
   localparam logic [TERM_W-1:0] LAST_TERM = TERM_W'(POLY_TERMS - 1);

   state_type          state_ff, state_in;
   logic [TERM_W-1:0]  term_ff, term_in;
   logic               accept;

   assign accept = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   // Next state and term counter.
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      case (state_ff)
         ST_IDLE: begin
            term_in = LAST_TERM;
            if (accept) begin
               state_in = req_action ? ST_DECIDE : ST_MUL_LO;
            end
         end
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_ADD;
         ST_ADD: begin
            if (term_ff == '0) begin
               state_in = ST_SCALE;
            end else begin
               term_in  = term_ff - 1'b1;
               state_in = ST_MUL_LO;
            end
         end
         ST_SCALE:  state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath controls.
   always_comb begin
      ctl.op     = OP_NONE;
      ctl.term   = TERM_IDX_W'(term_ff);
      ctl.ready  = (state_ff == ST_IDLE);
      ctl.finish = 1'b0;
      case (state_ff)
         ST_IDLE:   ctl.op = accept ? OP_CLEAR : OP_NONE;
         ST_MUL_LO: ctl.op = OP_MUL_LO;
         ST_MUL_HI: ctl.op = OP_MUL_HI;
         ST_ADD:    ctl.op = OP_ADD;
         ST_SCALE:  ctl.op = OP_SCALE;
         ST_ROUND:  ctl.op = OP_ROUND;
         ST_DECIDE: ctl.finish = out_free;
         default:   ctl.op = OP_NONE;
      endcase
   end

   `CBBS_ASSERT_NEXT(a_mul_pair, clock, reset, state_ff == ST_MUL_LO, state_ff == ST_MUL_HI)
   `CBBS_ASSERT_NEXT(a_last_term, clock, reset, state_ff == ST_ADD && term_ff == '0,
                     state_ff == ST_SCALE)
   `CBBS_ASSERT_NEXT(a_term_step, clock, reset, state_ff == ST_ADD && term_ff != '0,
                     state_ff == ST_MUL_LO && term_ff + 1'b1 == $past(term_ff))

endmodule

>>> hw/rtl/cbbs_datapath.sv
module cbbs_datapath #(
   parameter int ADC_BITS = cbbs_pkg::DEF_ADC_BITS
) (
   input  logic                         clock,
   input  cbbs_pkg::cbbs_ctl_type       ctl,
   input  logic [cbbs_pkg::CMD_W-1:0]   cmd,
   output logic [ADC_BITS-1:0]          counts
);
   import cbbs_pkg::*;

   localparam int SCALED_W = ACC_W + ADC_BITS;
   localparam int Q_W      = SCALED_W - FRAC_W + 1;
   localparam logic [ADC_BITS-1:0] MAXC = {ADC_BITS{1'b1}};

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [CMD_W-1:0]         cmd_ff, cmd_in;
   logic [PLO_W-1:0]         plo_ff, plo_in;
   logic signed [PHI_W-1:0]  phi_ff, phi_in;
   logic [SCALED_W-1:0]      scaled_ff, scaled_in;
   logic                     neg_ff, neg_in;
   logic [ADC_BITS-1:0]      counts_ff, counts_in;

   logic signed [PHI_W:0]    hi_prod;
   logic signed [PHI_W:0]    hi_sum;
   logic signed [SHIFT_W-1:0] shifted;
   logic signed [ACC_W-1:0]  coef;
   logic [SUM_W-1:0]         sum;
   logic [Q_W-1:0]           q;

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      cmd_ff    <= cmd_in;
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      scaled_ff <= scaled_in;
      neg_ff    <= neg_in;
      counts_ff <= counts_in;
   end

   always_comb begin
      acc_in    = acc_ff;
      cmd_in    = cmd_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      scaled_in = scaled_ff;
      neg_in    = neg_ff;
      counts_in = counts_ff;

      hi_prod = $signed(acc_ff[ACC_W-1:HALF_W]) * $signed({1'b0, cmd_ff});
      hi_sum  = hi_prod + $signed((PHI_W + 1)'(plo_ff[PLO_W-1:HALF_W]));
      shifted = $signed({phi_ff, plo_ff[HALF_W-1:CMD_FRAC_W]});
      coef    = (ctl.term < TERM_IDX_W'(COEF_COUNT)) ? COEF_TABLE[ctl.term] : '0;
      // The rounding half is the carry-in: bit 9 of the product.
      sum     = SUM_W'(shifted) + SUM_W'(coef) + SUM_W'(plo_ff[CMD_FRAC_W-1]);
      q       = Q_W'(scaled_ff[SCALED_W-1:FRAC_W]) + Q_W'(scaled_ff[FRAC_W-1]);

      case (ctl.op)
         OP_CLEAR: begin
            acc_in = '0;
            cmd_in = cmd;
         end
         OP_MUL_LO: plo_in = PLO_W'(acc_ff[HALF_W-1:0] * cmd_ff);
         OP_MUL_HI: phi_in = hi_sum[PHI_W-1:0];
         OP_ADD: begin
            if (sum[SUM_W-1:ACC_W-1] == '0 || sum[SUM_W-1:ACC_W-1] == '1) begin
               acc_in = sum[ACC_W-1:0];
            end else if (sum[SUM_W-1]) begin
               acc_in = {1'b1, {(ACC_W - 1){1'b0}}};
            end else begin
               acc_in = {1'b0, {(ACC_W - 1){1'b1}}};
            end
         end
         OP_SCALE: begin
            // Multiply by 2^ADC_BITS - 1 as a shift and a subtract.
            scaled_in = (SCALED_W'(acc_ff) << ADC_BITS) - SCALED_W'(acc_ff);
            neg_in    = acc_ff[ACC_W-1];
         end
         OP_ROUND: begin
            if (neg_ff) begin
               counts_in = '0;
            end else if (q > Q_W'(MAXC)) begin
               counts_in = MAXC;
            end else begin
               counts_in = q[ADC_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign counts = counts_ff;

endmodule

>>> hw/rtl/calibrated_bang_bang_servo.sv
// Calibrated bang-bang servo controller.
// Request channel (req_valid / req_stall): req_action 0 is a position
// command in unsigned Q4.10, mapped through the calibration polynomial to
// a setpoint in converter counts; req_action 1 is a position sample tick.
// Every request produces one response on rsp_valid / rsp_stall carrying the
// drive outputs, the busy flag and the current setpoint.
// A command runs its polynomial on one shared multiply-add unit, one term
// at a time in steps of low half product, high half product, and round and
// add, then count conversion (scale, round) and a decide step that updates
// the state and loads the response register. The next request is taken
// once the controller has gone back to idle.
// A sample tick skips the polynomial and goes straight to the decide step.
// Requests are stalled while an item is in progress.
// A new request is taken while a response still waits; if the response
// register is still full when the next item finishes, that item holds until
// the receiver drops rsp_stall.
// Reset clears the setpoint to zero and the direction to idle.
`include "calibrated_bang_bang_servo_macros.svh"

module calibrated_bang_bang_servo #(
   parameter int POLY_TERMS = cbbs_pkg::DEF_POLY_TERMS,
   parameter int ADC_BITS   = cbbs_pkg::DEF_ADC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [cbbs_pkg::CMD_W-1:0]  req_position_cmd,
   input  logic [ADC_BITS-1:0]         req_adc_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_drive_right,
   output logic                        rsp_drive_left,
   output logic                        rsp_busy_res,
   output logic [ADC_BITS-1:0]         rsp_target_counts
);
   import cbbs_pkg::*;

   cbbs_ctl_type         ctl;
   logic [ADC_BITS-1:0]  counts;
   logic                 out_free;
   logic                 accept;

   logic                 action_ff, action_in;
   logic [ADC_BITS-1:0]  sample_ff, sample_in;
   logic [ADC_BITS-1:0]  setpoint_ff, setpoint_in;
   dir_type              dir_ff, dir_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 right_ff, right_in;
   logic                 left_ff, left_in;
   logic                 busy_ff, busy_in;
   logic [ADC_BITS-1:0]  target_ff, target_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign accept   = req_valid && ctl.ready;

   cbbs_ctrl #(
      .POLY_TERMS (POLY_TERMS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .out_free   (out_free),
      .ctl        (ctl)
   );

   cbbs_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_datapath (
      .clock  (clock),
      .ctl    (ctl),
      .cmd    (req_position_cmd),
      .counts (counts)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff  <= '0;
         dir_ff       <= DIR_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         setpoint_ff  <= setpoint_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff <= action_in;
      sample_ff <= sample_in;
      right_ff  <= right_in;
      left_ff   <= left_in;
      busy_ff   <= busy_in;
      target_ff <= target_in;
   end

   always_comb begin
      action_in    = action_ff;
      sample_in    = sample_ff;
      setpoint_in  = setpoint_ff;
      dir_in       = dir_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      right_in     = right_ff;
      left_in      = left_ff;
      busy_in      = busy_ff;
      target_in    = target_ff;

      if (accept) begin
         action_in = req_action;
         sample_in = req_adc_sample;
      end

      if (ctl.finish) begin
         if (!action_ff) begin
            // A command replaces any move in progress.
            setpoint_in = counts;
            if (sample_ff < counts) begin
               dir_in = DIR_RIGHT;
            end else if (sample_ff > counts) begin
               dir_in = DIR_LEFT;
            end else begin
               dir_in = DIR_IDLE;
            end
         end else begin
            case (dir_ff)
               DIR_RIGHT: dir_in = (sample_ff >= setpoint_ff) ? DIR_IDLE : DIR_RIGHT;
               DIR_LEFT:  dir_in = (sample_ff <= setpoint_ff) ? DIR_IDLE : DIR_LEFT;
               DIR_IDLE:  dir_in = DIR_IDLE;
               default:   dir_in = DIR_IDLE;
            endcase
         end
         rsp_valid_in = 1'b1;
         right_in     = (dir_in == DIR_RIGHT);
         left_in      = (dir_in == DIR_LEFT);
         busy_in      = (dir_in != DIR_IDLE);
         target_in    = setpoint_in;
      end
   end

   assign req_stall         = !ctl.ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_right   = right_ff;
   assign rsp_drive_left    = left_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_target_counts = target_ff;

   `CBBS_ASSERT_NEXT(a_finish_shows, clock, reset, ctl.finish,
                     rsp_valid_ff && target_ff == setpoint_ff)
   `CBBS_ASSERT_NEXT(a_taken_clears, clock, reset, rsp_valid_ff && !rsp_stall && !ctl.finish,
                     !rsp_valid_ff)
   `CBBS_ASSERT_SAME(a_busy_drive, clock, reset, rsp_valid_ff,
                     busy_ff == (right_ff || left_ff) && !(right_ff && left_ff))

endmodule

>>> tb/calibrated_bang_bang_servo_tb.sv
module calibrated_bang_bang_servo_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cbbs_pkg::*;

   localparam int ADC_W     = DEF_ADC_BITS;
   localparam int ADC_MAX   = (1 << ADC_W) - 1;
   localparam int CAL_TERMS = DEF_POLY_TERMS;
   localparam int XW        = 160;

   localparam logic ACT_COMMAND = 1'b0;
   localparam logic ACT_SAMPLE  = 1'b1;

   localparam logic signed [XW-1:0] SAT_HI    = (160'sd1 <<< (ACC_W - 1)) - 160'sd1;
   localparam logic signed [XW-1:0] SAT_LO    = -(160'sd1 <<< (ACC_W - 1));
   localparam logic signed [XW-1:0] HALF_CMD  = 160'sd1 <<< (CMD_FRAC_W - 1);
   localparam logic signed [XW-1:0] HALF_FRAC = 160'sd1 <<< (FRAC_W - 1);

   typedef struct packed {
      logic             right;
      logic             left;
      logic             busy;
      logic [ADC_W-1:0] target;
   } drive_word_type;

   // Tracks setpoint and direction and queues the response each transfer will produce.
   class servo_shadow_type;
      logic signed [ACC_W-1:0] coef_q [CAL_TERMS];
      logic [ADC_W-1:0]        setpoint;
      dir_type                 heading;
      drive_word_type          pending_drives [$];

      function new();
         logic [255:0] num;
         logic [255:0] den;
         logic [72:0]  spec;
         int           k;
         for (k = 0; k < CAL_TERMS; k++) begin
            // Sign, decimal exponent and mantissa of each calibration term.
            case (k)
               0:  spec = {1'b0, 8'd19, 64'd10940883381103002};
               1:  spec = {1'b0, 8'd18, 64'd33836477185904892};
               2:  spec = {1'b1, 8'd18, 64'd86168336840589527};
               3:  spec = {1'b0, 8'd18, 64'd72898864709400185};
               4:  spec = {1'b0, 8'd19, 64'd65634869157701475};
               5:  spec = {1'b1, 8'd18, 64'd43041284300853841};
               6:  spec = {1'b0, 8'd18, 64'd27865035485863790};
               7:  spec = {1'b1, 8'd19, 64'd84485921561660623};
               8:  spec = {1'b0, 8'd19, 64'd12295215776175377};
               9:  spec = {1'b1, 8'd21, 64'd36304431194088678};
               10: spec = {1'b1, 8'd21, 64'd11407813908880530};
               11: spec = {1'b0, 8'd23, 64'd69455207057115884};
               12: spec = {1'b0, 8'd23, 64'd15831820248467315};
               13: spec = {1'b1, 8'd24, 64'd24464645786585510};
               14: spec = {1'b0, 8'd25, 64'd12748257280927221};
               15: spec = {1'b0, 8'd27, 64'd64620006332451161};
               16: spec = {1'b1, 8'd27, 64'd28653037259852716};
               17: spec = {1'b0, 8'd28, 64'd33937637701018807};
               18: spec = {1'b1, 8'd29, 64'd14775025027190523};
               19: spec = {1'b1, 8'd32, 64'd82774635566028758};
               default: spec = {1'b0, 8'd32, 64'd16178431560148211};
            endcase
            den = 256'd1;
            repeat (spec[71:64]) den = den * 256'd10;
            // One extra fraction bit, then halve with rounding up.
            num = (256'(spec[63:0]) << (FRAC_W + 1)) / den;
            num = (num + 256'd1) >> 1;
            coef_q[k] = spec[72] ? -num[ACC_W-1:0] : num[ACC_W-1:0];
         end
         setpoint = '0;
         heading  = DIR_IDLE;
      endfunction

      function logic [ADC_W-1:0] setpoint_for_cmd(input logic [CMD_W-1:0] x);
         logic signed [XW-1:0] acc;
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] scaled;
         int                   k;
         acc = '0;
         xs  = XW'(x);
         for (k = CAL_TERMS; k > 0; k--) begin
            acc = ((acc * xs) + HALF_CMD) >>> CMD_FRAC_W;
            acc = acc + coef_q[k-1];
            if (acc > SAT_HI) acc = SAT_HI;
            else if (acc < SAT_LO) acc = SAT_LO;
         end
         if (acc < 0) return '0;
         scaled = (acc * ADC_MAX + HALF_FRAC) >>> FRAC_W;
         if (scaled > ADC_MAX) return ADC_W'(ADC_MAX);
         return scaled[ADC_W-1:0];
      endfunction

      function void take_request(input logic action, input logic [CMD_W-1:0] cmd,
                                 input logic [ADC_W-1:0] sample);
         drive_word_type word;
         if (action == ACT_COMMAND) begin
            setpoint = setpoint_for_cmd(cmd);
            if (sample < setpoint) heading = DIR_RIGHT;
            else if (sample > setpoint) heading = DIR_LEFT;
            else heading = DIR_IDLE;
         end else begin
            if (heading == DIR_RIGHT && sample >= setpoint) heading = DIR_IDLE;
            else if (heading == DIR_LEFT && sample <= setpoint) heading = DIR_IDLE;
         end
         word.right  = (heading == DIR_RIGHT);
         word.left   = (heading == DIR_LEFT);
         word.busy   = (heading != DIR_IDLE);
         word.target = setpoint;
         pending_drives.push_back(word);
      endfunction

      function string check_response(input drive_word_type got);
         drive_word_type want;
         if (pending_drives.size() == 0)
            return $sformatf("response with none outstanding: r%0b l%0b busy %0b target %0d",
                             got.right, got.left, got.busy, got.target);
         want = pending_drives.pop_front();
         if (got.right !== want.right || got.left !== want.left ||
             got.busy !== want.busy || got.target !== want.target)
            return $sformatf("got r%0b l%0b busy %0b tgt %0d, want r%0b l%0b busy %0b tgt %0d",
                             got.right, got.left, got.busy, got.target,
                             want.right, want.left, want.busy, want.target);
         return "";
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_action = 1'b0;
   logic [CMD_W-1:0]  req_position_cmd = '0;
   logic [ADC_W-1:0]  req_adc_sample = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_drive_right;
   logic              rsp_drive_left;
   logic              rsp_busy_res;
   logic [ADC_W-1:0]  rsp_target_counts;

   servo_shadow_type sb;
   int               mismatches = 0;
   int               items_sent = 0;
   int               stall_left = 0;
   bit               quiet = 1'b0;

   calibrated_bang_bang_servo u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_position_cmd  (req_position_cmd),
      .req_adc_sample    (req_adc_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_drive_right   (rsp_drive_right),
      .rsp_drive_left    (rsp_drive_left),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_target_counts (rsp_target_counts)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Stall the response side now and then, sometimes holding it for a random stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(99) < 3) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Handshake signals only change at the rising edge, so the falling edge
   // sees exactly what the next rising edge will act on.
   always @(negedge clock) begin : rsp_monitor
      string why;
      if (!reset && rsp_valid && !rsp_stall) begin
         why = sb.check_response({rsp_drive_right, rsp_drive_left, rsp_busy_res,
                                  rsp_target_counts});
         if (why.len() != 0) report_mismatch(why);
      end
   end

   task automatic send_item(input logic action, input logic [CMD_W-1:0] cmd,
                            input logic [ADC_W-1:0] sample);
      if (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(3) == 0) ? $urandom_range(90, 20) : $urandom_range(4, 1))
            @(posedge clock);
      end
      req_action       <= action;
      req_position_cmd <= cmd;
      req_adc_sample   <= sample;
      req_valid        <= 1'b1;
      do @(negedge clock); while (req_stall);
      sb.take_request(action, cmd, sample);
      items_sent++;
      @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_drives.size() != 0);
   endtask

   // A command followed by samples that walk toward the setpoint, with some
   // noise; a walk that runs out of ticks is cut off by the next command.
   task automatic run_move();
      logic [CMD_W-1:0] cmd;
      int               pos;
      int               goal;
      int               ticks;
      case ($urandom_range(19))
         0:       cmd = CMD_W'($urandom_range(16383, 10240));
         1:       cmd = 14'd0;
         2:       cmd = 14'd10239;
         default: cmd = CMD_W'($urandom_range(10239));
      endcase
      pos  = $urandom_range(ADC_MAX);
      goal = sb.setpoint_for_cmd(cmd);
      send_item(ACT_COMMAND, cmd, ADC_W'(pos));
      ticks = $urandom_range(14, 1);
      repeat (ticks) begin
         if ($urandom_range(9) == 0) pos = $urandom_range(ADC_MAX);
         else if (pos < goal) pos = pos + $urandom_range((goal - pos) / 3 + 2, 1);
         else if (pos > goal) pos = pos - $urandom_range((pos - goal) / 3 + 2, 1);
         else pos = pos + $urandom_range(2) - 1;
         if (pos > ADC_MAX) pos = ADC_MAX;
         if (pos < 0) pos = 0;
         send_item(ACT_SAMPLE, CMD_W'($urandom), ADC_W'(pos));
      end
   endtask

   initial begin : stimulus
      logic [ADC_W-1:0] aim;
      bit               paused;
      paused = 1'b0;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sample while idle, reaching the setpoint exactly, overshoot both ways.
      send_item(ACT_SAMPLE, 14'h3FFF, 12'd0);
      aim = sb.setpoint_for_cmd(14'd0);
      send_item(ACT_COMMAND, 14'd0, 12'd0);
      send_item(ACT_SAMPLE, 14'd0, aim);
      aim = sb.setpoint_for_cmd(14'd10239);
      send_item(ACT_COMMAND, 14'd10239, 12'hFFF);
      send_item(ACT_SAMPLE, 14'd0, 12'hFFF);
      send_item(ACT_SAMPLE, 14'd0, aim + 12'd1);
      send_item(ACT_SAMPLE, 14'd0, 12'd0);
      // Command beyond the nominal range.
      send_item(ACT_COMMAND, 14'h3FFF, 12'd0);
      send_item(ACT_SAMPLE, 14'd0, 12'hFFF);
      // Sample already on target when the command arrives.
      aim = sb.setpoint_for_cmd(14'd5000);
      send_item(ACT_COMMAND, 14'd5000, aim);
      send_item(ACT_SAMPLE, 14'h1555, 12'd0);
      // A command replacing a move in progress.
      send_item(ACT_COMMAND, 14'h2AAA, 12'h555);
      send_item(ACT_COMMAND, 14'h1555, 12'hAAA);
      send_item(ACT_SAMPLE, 14'h2AAA, 12'hAAA);
      send_item(ACT_SAMPLE, 14'h1555, 12'h555);
      send_item(ACT_COMMAND, 14'd1024, 12'd0);
      send_item(ACT_SAMPLE, 14'd0, 12'hFFF);
      send_item(ACT_COMMAND, 14'd8000, 12'hFFF);
      send_item(ACT_SAMPLE, 14'd0, 12'd0);
      drain_responses();

      while (items_sent < 720) begin
         quiet = (items_sent >= 300 && items_sent < 430);
         run_move();
         if (items_sent >= 500 && !paused) begin
            drain_responses();
            paused = 1'b1;
         end
      end
      quiet = 1'b0;

      drain_responses();
      repeat (80) @(posedge clock);
      if (mismatches == 0) begin
         $display("calibrated_bang_bang_servo regression: pass");
      end else begin
         $display("calibrated_bang_bang_servo regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #10ms;
      $display("calibrated_bang_bang_servo regression: fail");
      $finish;
   end

endmodule
